>>> rtl/cosine_sum_window_generator_top_assert.svh
// Assertion macros used by the window generator top level.
`ifndef COSINE_SUM_WINDOW_GENERATOR_TOP_ASSERT_SVH
`define COSINE_SUM_WINDOW_GENERATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define CSW_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define CSW_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define CSW_ASSERT_IMPL(lbl, ck, rn, ante, cons)
`define CSW_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

>>> rtl/csw_pkg.sv
`timescale 1ns / 1ps
package csw_pkg;
  localparam int INDEX_BITS = 16;
  localparam int FRACTION_BITS = 16;
  localparam int PHASE_BITS = 32;
  localparam int OUT_W = 19;
  localparam int COEF_W = 17;
  localparam int IN_TDATA_W = 16;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_ADDR_W = 4;
  localparam int HORNER_STEPS = 4;
  localparam int ACC_W = 52;
  localparam int ACC_SHIFT = 46 - FRACTION_BITS;

  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic [31:0] PI_Q30 = 32'd3373259426;

  localparam logic [6:0] SIN_K [HORNER_STEPS] = '{7'd72, 7'd42, 7'd20, 7'd6};
  localparam logic [6:0] COS_K [HORNER_STEPS] = '{7'd56, 7'd30, 7'd12, 7'd2};
  localparam logic [29:0] SIN_M [HORNER_STEPS] = '{
    30'(64'd1073741824 / 72), 30'(64'd1073741824 / 42),
    30'(64'd1073741824 / 20), 30'(64'd1073741824 / 6)};
  localparam logic [29:0] COS_M [HORNER_STEPS] = '{
    30'(64'd1073741824 / 56), 30'(64'd1073741824 / 30),
    30'(64'd1073741824 / 12), 30'(64'd1073741824 / 2)};

  typedef struct packed {
    logic valid;
    logic err;
  } csw_tag_t;

  typedef enum logic [1:0] {
    REG_LENGTH = 2'd0,
    REG_COEF0  = 2'd1,
    REG_COEF1  = 2'd2,
    REG_COEF2  = 2'd3
  } csw_reg_t;
endpackage

>>> rtl/csw_div.sv
`timescale 1ns / 1ps
module csw_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            ce,
  input  logic                            in_valid,
  input  logic [csw_pkg::INDEX_BITS-1:0]  n_i,
  input  logic [csw_pkg::INDEX_BITS-1:0]  len_i,
  output csw_pkg::csw_tag_t               tag_o,
  output logic [csw_pkg::PHASE_BITS-1:0]  phase_o
);
  localparam int IB = csw_pkg::INDEX_BITS;
  localparam int PB = csw_pkg::PHASE_BITS;

  csw_pkg::csw_tag_t tag_r [0:PB];
  logic [IB-1:0]     rem_r [0:PB-1];
  logic [PB-1:0]     q_r   [0:PB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r[0] <= '0;
    end else if (ce) begin
      tag_r[0].valid <= in_valid;
      tag_r[0].err   <= (n_i >= len_i);
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      rem_r[0] <= n_i;
      q_r[0]   <= '0;
    end
  end

  // One quotient bit per stage: the phase is n * 2^32 / N as a turn fraction.
  for (genvar j = 1; j <= PB; j++) begin : g_step
    logic [IB:0] rem2;
    logic        ge;
    assign rem2 = {rem_r[j-1], 1'b0};
    assign ge   = (rem2 >= {1'b0, len_i});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r[j] <= '0;
      end else if (ce) begin
        tag_r[j] <= tag_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        q_r[j] <= {q_r[j-1][PB-2:0], ge};
      end
    end

    if (j < PB) begin : g_rem
      always_ff @(posedge clk) begin
        if (ce) begin
          rem_r[j] <= ge ? IB'(rem2 - {1'b0, len_i}) : IB'(rem2);
        end
      end
    end
  end

  assign tag_o   = tag_r[PB];
  assign phase_o = q_r[PB];
endmodule

>>> rtl/csw_cos.sv
`timescale 1ns / 1ps
module csw_cos (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           ce,
  input  csw_pkg::csw_tag_t              tag_i,
  input  logic [csw_pkg::PHASE_BITS-1:0] phase_i,
  output csw_pkg::csw_tag_t              tag_o,
  output logic signed [31:0]             cos_o
);
  localparam int NS = csw_pkg::HORNER_STEPS;

  // Front: octant fold, angle in radians, angle squared.
  csw_pkg::csw_tag_t tag0_r, tag1_r, tag2_r;
  logic [2:0]        oct0_r, oct1_r, oct2_r;
  logic [29:0]       r0_r, x1_r, x2_r, sq2_r;
  logic [61:0]       ang_prod;
  logic [59:0]       sq_prod;

  assign ang_prod = {32'd0, r0_r} * {30'd0, csw_pkg::PI_Q30};
  assign sq_prod  = {30'd0, x1_r} * {30'd0, x1_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag0_r <= '0;
      tag1_r <= '0;
      tag2_r <= '0;
    end else if (ce) begin
      tag0_r <= tag_i;
      tag1_r <= tag0_r;
      tag2_r <= tag1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      oct0_r <= phase_i[31:29];
      r0_r   <= phase_i[29] ? (30'h2000_0000 - {1'b0, phase_i[28:0]})
                            : {1'b0, phase_i[28:0]};
      oct1_r <= oct0_r;
      x1_r   <= ang_prod[60:31];
      oct2_r <= oct1_r;
      x2_r   <= x1_r;
      sq2_r  <= sq_prod[59:30];
    end
  end

  // Horner steps, three stages each: product, reciprocal estimate, fix-up.
  csw_pkg::csw_tag_t in_tag [NS];
  logic [2:0]        in_oct [NS];
  logic [29:0]       in_x   [NS];
  logic [29:0]       in_sq  [NS];
  logic [30:0]       in_t   [NS];

  csw_pkg::csw_tag_t a_tag_r [NS], b_tag_r [NS], c_tag_r [NS];
  logic [2:0]        a_oct_r [NS], b_oct_r [NS], c_oct_r [NS];
  logic [29:0]       a_x_r   [NS], b_x_r   [NS], c_x_r   [NS];
  logic [29:0]       a_sq_r  [NS], b_sq_r  [NS], c_sq_r  [NS];
  logic [29:0]       a_v_r   [NS], b_v_r   [NS], b_qe_r  [NS];
  logic [30:0]       c_t_r   [NS];

  for (genvar j = 0; j < NS; j++) begin : g_horner
    logic [60:0] hprod;
    logic [59:0] mprod;
    logic [36:0] kprod;
    logic [36:0] rem;
    logic [29:0] q;
    logic        a_sin, b_sin;
    logic [29:0] recip;
    logic [6:0]  kb;

    if (j == 0) begin : g_first
      assign in_tag[j] = tag2_r;
      assign in_oct[j] = oct2_r;
      assign in_x[j]   = x2_r;
      assign in_sq[j]  = sq2_r;
      assign in_t[j]   = csw_pkg::Q30_ONE;
    end else begin : g_next
      assign in_tag[j] = c_tag_r[j-1];
      assign in_oct[j] = c_oct_r[j-1];
      assign in_x[j]   = c_x_r[j-1];
      assign in_sq[j]  = c_sq_r[j-1];
      assign in_t[j]   = c_t_r[j-1];
    end

    // Octants 1, 2, 5 and 6 evaluate the sine series, the others the cosine.
    assign a_sin = a_oct_r[j][1] ^ a_oct_r[j][0];
    assign b_sin = b_oct_r[j][1] ^ b_oct_r[j][0];
    assign recip = a_sin ? csw_pkg::SIN_M[j] : csw_pkg::COS_M[j];
    assign kb    = b_sin ? csw_pkg::SIN_K[j] : csw_pkg::COS_K[j];

    assign hprod = {31'd0, in_sq[j]} * {30'd0, in_t[j]};
    assign mprod = {30'd0, a_v_r[j]} * {30'd0, recip};
    assign kprod = {7'd0, b_qe_r[j]} * {30'd0, kb};
    // The estimate is low by at most one, so one compare corrects it.
    assign rem   = {7'd0, b_v_r[j]} - kprod;
    assign q     = b_qe_r[j] + {29'd0, (rem >= {30'd0, kb})};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        a_tag_r[j] <= '0;
        b_tag_r[j] <= '0;
        c_tag_r[j] <= '0;
      end else if (ce) begin
        a_tag_r[j] <= in_tag[j];
        b_tag_r[j] <= a_tag_r[j];
        c_tag_r[j] <= b_tag_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        a_oct_r[j] <= in_oct[j];
        a_x_r[j]   <= in_x[j];
        a_sq_r[j]  <= in_sq[j];
        a_v_r[j]   <= hprod[59:30];
        b_oct_r[j] <= a_oct_r[j];
        b_x_r[j]   <= a_x_r[j];
        b_sq_r[j]  <= a_sq_r[j];
        b_v_r[j]   <= a_v_r[j];
        b_qe_r[j]  <= mprod[59:30];
        c_oct_r[j] <= b_oct_r[j];
        c_x_r[j]   <= b_x_r[j];
        c_sq_r[j]  <= b_sq_r[j];
        c_t_r[j]   <= csw_pkg::Q30_ONE - {1'b0, q};
      end
    end
  end

  // Back end: sine needs one more multiply by x, then the octant sign.
  csw_pkg::csw_tag_t f1_tag_r, f2_tag_r;
  logic [2:0]        f1_oct_r;
  logic [30:0]       f1_mag_r;
  logic signed [31:0] f2_cos_r;
  logic [60:0]       sin_prod;
  logic              f_sin, f_neg;

  assign sin_prod = {31'd0, c_x_r[NS-1]} * {30'd0, c_t_r[NS-1]};
  assign f_sin    = c_oct_r[NS-1][1] ^ c_oct_r[NS-1][0];
  assign f_neg    = f1_oct_r[2] ^ f1_oct_r[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_tag_r <= '0;
      f2_tag_r <= '0;
    end else if (ce) begin
      f1_tag_r <= c_tag_r[NS-1];
      f2_tag_r <= f1_tag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      f1_oct_r <= c_oct_r[NS-1];
      f1_mag_r <= f_sin ? sin_prod[60:30] : c_t_r[NS-1];
      f2_cos_r <= f_neg ? -$signed({1'b0, f1_mag_r}) : $signed({1'b0, f1_mag_r});
    end
  end

  assign tag_o = f2_tag_r;
  assign cos_o = f2_cos_r;
endmodule

>>> rtl/csw_mix.sv
`timescale 1ns / 1ps
module csw_mix (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              ce,
  input  csw_pkg::csw_tag_t                 tag_i,
  input  logic signed [31:0]                cos1_i,
  input  logic signed [31:0]                cos2_i,
  input  logic [csw_pkg::COEF_W-1:0]        a0_i,
  input  logic [csw_pkg::COEF_W-1:0]        a1_i,
  input  logic [csw_pkg::COEF_W-1:0]        a2_i,
  output csw_pkg::csw_tag_t                 tag_o,
  output logic signed [csw_pkg::OUT_W-1:0]  value_o
);
  localparam int AW = csw_pkg::ACC_W;
  localparam int SH = csw_pkg::ACC_SHIFT;
  localparam logic signed [AW-1:0] HI = AW'((64'sd1 <<< (csw_pkg::OUT_W - 1)) - 1);
  localparam logic signed [AW-1:0] LO = AW'(-(64'sd1 <<< (csw_pkg::OUT_W - 1)));
  localparam logic signed [AW-1:0] HALF = AW'(64'sd1 <<< (SH - 1));

  csw_pkg::csw_tag_t m1_tag_r, m2_tag_r, m3_tag_r;
  logic signed [49:0] p0_r, p1_r, p2_r;
  logic signed [AW-1:0] acc_r;
  logic signed [csw_pkg::OUT_W-1:0] val_r;
  logic signed [49:0] p1, p2;
  logic signed [AW-1:0] scaled;

  assign p1 = $signed({1'b0, a1_i}) * cos1_i;
  assign p2 = $signed({1'b0, a2_i}) * cos2_i;
  // Rounds half up: adding one half then an arithmetic shift floors.
  assign scaled = (acc_r + HALF) >>> SH;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_tag_r <= '0;
      m2_tag_r <= '0;
      m3_tag_r <= '0;
    end else if (ce) begin
      m1_tag_r <= tag_i;
      m2_tag_r <= m1_tag_r;
      m3_tag_r <= m2_tag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      p0_r  <= $signed({3'd0, a0_i, 30'd0});
      p1_r  <= p1;
      p2_r  <= p2;
      acc_r <= AW'(p0_r) - AW'(p1_r) + AW'(p2_r);
      if (m2_tag_r.err) begin
        val_r <= '0;
      end else if (scaled > HI) begin
        val_r <= csw_pkg::OUT_W'(HI);
      end else if (scaled < LO) begin
        val_r <= csw_pkg::OUT_W'(LO);
      end else begin
        val_r <= csw_pkg::OUT_W'(scaled);
      end
    end
  end

  assign tag_o   = m3_tag_r;
  assign value_o = val_r;
endmodule

>>> rtl/cosine_sum_window_generator_top.sv
// Throughput: one request per cycle while the skid slot is empty; the 33-stage
// phase divider, the two 17-stage cosine pipelines and the 3-stage mixer all
// take a request each cycle, and the whole pipeline stalls while it is full.
// Reset: synchronous, active low; clears all valid bits and loads the Hann
// setting (N = 256, a0 = a1 = 0.5, a2 = 0).
`timescale 1ns / 1ps
`include "cosine_sum_window_generator_top_assert.svh"
module cosine_sum_window_generator_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [csw_pkg::IN_TDATA_W-1:0]      in_tdata,   // [15:0] sample_index
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [csw_pkg::OUT_TDATA_W-1:0]     out_tdata,  // [18:0] window_value, zero fill
  output logic                                out_tuser,  // [0] index_error
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [csw_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [31:0]                         cfg_pwdata,
  output logic [31:0]                         cfg_prdata,
  output logic                                cfg_pready
);
  localparam int IB = csw_pkg::INDEX_BITS;
  localparam int CW = csw_pkg::COEF_W;
  localparam int OW = csw_pkg::OUT_W;

  logic [IB-1:0] len_r;
  logic [CW-1:0] coef0_r, coef1_r, coef2_r;
  csw_pkg::csw_reg_t reg_sel;
  logic cfg_wr;

  assign cfg_pready = 1'b1;
  assign reg_sel    = csw_pkg::csw_reg_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= IB'(256);
      coef0_r <= CW'(32768);
      coef1_r <= CW'(32768);
      coef2_r <= '0;
    end else if (cfg_wr) begin
      case (reg_sel)
        csw_pkg::REG_LENGTH: len_r   <= IB'(cfg_pwdata);
        csw_pkg::REG_COEF0:  coef0_r <= CW'(cfg_pwdata);
        csw_pkg::REG_COEF1:  coef1_r <= CW'(cfg_pwdata);
        csw_pkg::REG_COEF2:  coef2_r <= CW'(cfg_pwdata);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      csw_pkg::REG_LENGTH: cfg_prdata = 32'(len_r);
      csw_pkg::REG_COEF0:  cfg_prdata = 32'(coef0_r);
      csw_pkg::REG_COEF1:  cfg_prdata = 32'(coef1_r);
      csw_pkg::REG_COEF2:  cfg_prdata = 32'(coef2_r);
      default:             cfg_prdata = '0;
    endcase
  end

  // The whole pipeline advances together unless the skid slot is occupied.
  logic ce;
  logic skid_valid_r;
  assign ce        = !skid_valid_r;
  assign in_tready = ce;

  csw_pkg::csw_tag_t div_tag, cos1_tag, cos2_tag, mix_tag;
  logic [csw_pkg::PHASE_BITS-1:0] phase1, phase2;
  logic signed [31:0] cos1, cos2;
  logic signed [OW-1:0] mix_value;

  csw_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ce       (ce),
    .in_valid (in_tvalid),
    .n_i      (IB'(in_tdata)),
    .len_i    (len_r),
    .tag_o    (div_tag),
    .phase_o  (phase1)
  );

  // The second harmonic is twice the phase, modulo one turn.
  assign phase2 = {phase1[csw_pkg::PHASE_BITS-2:0], 1'b0};

  csw_cos u_cos1 (
    .clk     (clk),
    .rst_n   (rst_n),
    .ce      (ce),
    .tag_i   (div_tag),
    .phase_i (phase1),
    .tag_o   (cos1_tag),
    .cos_o   (cos1)
  );

  csw_cos u_cos2 (
    .clk     (clk),
    .rst_n   (rst_n),
    .ce      (ce),
    .tag_i   (div_tag),
    .phase_i (phase2),
    .tag_o   (cos2_tag),
    .cos_o   (cos2)
  );

  csw_mix u_mix (
    .clk     (clk),
    .rst_n   (rst_n),
    .ce      (ce),
    .tag_i   (cos1_tag),
    .cos1_i  (cos1),
    .cos2_i  (cos2),
    .a0_i    (coef0_r),
    .a1_i    (coef1_r),
    .a2_i    (coef2_r),
    .tag_o   (mix_tag),
    .value_o (mix_value)
  );

  // Output register with one skid entry behind it.
  logic              out_valid_r;
  logic signed [OW-1:0] out_value_r, skid_value_r;
  logic              out_err_r, skid_err_r;
  logic              push;

  assign push = ce && mix_tag.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!skid_valid_r) begin
      if (push) begin
        if (out_valid_r && !out_tready) begin
          skid_valid_r <= 1'b1;
        end else begin
          out_valid_r <= 1'b1;
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end else if (out_tready) begin
      skid_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid_r) begin
      if (push) begin
        if (out_valid_r && !out_tready) begin
          skid_value_r <= mix_value;
          skid_err_r   <= mix_tag.err;
        end else begin
          out_value_r <= mix_value;
          out_err_r   <= mix_tag.err;
        end
      end
    end else if (out_tready) begin
      out_value_r <= skid_value_r;
      out_err_r   <= skid_err_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(csw_pkg::OUT_TDATA_W - OW)'(0), out_value_r};
  assign out_tuser  = out_err_r;

  `CSW_ASSERT_IMPL(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r)
  `CSW_ASSERT_IMPL(a_err_gives_zero, clk, rst_n, out_valid_r && out_err_r, out_value_r == '0)
  `CSW_ASSERT_IMPL(a_lanes_aligned, clk, rst_n, 1'b1, cos1_tag.valid == cos2_tag.valid)
  `CSW_ASSERT_NEXT(a_skid_catches, clk, rst_n, push && out_valid_r && !out_tready, skid_valid_r)
endmodule

>>> tb/cosine_sum_window_generator_top_tb.sv
`timescale 1ns / 1ps
module cosine_sum_window_generator_top_tb;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 60;
  localparam longint unsigned ONE_Q30 = 64'd1073741824;
  localparam longint unsigned PI_TURN = 64'd3373259426;

  typedef struct {
    logic [csw_pkg::OUT_W-1:0] window_value;
    logic                      index_error;
  } window_result_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [csw_pkg::IN_TDATA_W-1:0]  in_tdata = '0;   // [15:0] sample_index
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [csw_pkg::OUT_TDATA_W-1:0] out_tdata;       // [18:0] window_value, zero fill
  logic                            out_tuser;       // [0] index_error
  logic                            cfg_psel = 1'b0;
  logic                            cfg_penable = 1'b0;
  logic                            cfg_pwrite = 1'b0;
  logic [csw_pkg::CFG_ADDR_W-1:0]  cfg_paddr = '0;
  logic [31:0]                     cfg_pwdata = '0;
  logic [31:0]                     cfg_prdata;
  logic                            cfg_pready;

  // Shadow copy of the window registers, matching the reset setting.
  bit [15:0] length_reg = 16'd256;
  bit [16:0] a0_reg = 17'd32768;
  bit [16:0] a1_reg = 17'd32768;
  bit [16:0] a2_reg = 17'd0;

  logic [15:0]    pending_index[$];
  window_result_t expected_samples[$];
  int             error_count = 0;
  int             idle_cycles = 0;
  logic           in_fire = 1'b0;
  int             gap_left = 0;
  int             burst_left = 1;
  int             stall_cycle = 0;

  cosine_sum_window_generator_top u_top (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint unsigned horner(longint unsigned x2, longint unsigned t,
                                             longint unsigned k);
    return ONE_Q30 - (((x2 * t) >> 30) / k);
  endfunction

  // Cosine of a 32-bit fraction of a turn, Q30, by octant folding and a short series.
  function automatic longint cos_turn(logic [31:0] phase);
    logic [2:0]      oct;
    longint unsigned r, x, x2, t, mag;
    oct = phase[31:29];
    r = {35'd0, phase[28:0]};
    if (oct[0]) r = 64'h2000_0000 - r;
    x = (r * PI_TURN) >> 31;
    x2 = (x * x) >> 30;
    if (oct == 3'd1 || oct == 3'd2 || oct == 3'd5 || oct == 3'd6) begin
      t = horner(x2, ONE_Q30, 72);
      t = horner(x2, t, 42);
      t = horner(x2, t, 20);
      t = horner(x2, t, 6);
      mag = (x * t) >> 30;
    end else begin
      t = horner(x2, ONE_Q30, 56);
      t = horner(x2, t, 30);
      t = horner(x2, t, 12);
      mag = horner(x2, t, 2);
    end
    if (oct >= 3'd2 && oct <= 3'd5) return -longint'(mag);
    return longint'(mag);
  endfunction

  function automatic window_result_t window_sample(logic [15:0] n);
    window_result_t  res;
    longint unsigned p1;
    logic [31:0]     p2;
    longint          acc, value;
    res.window_value = '0;
    res.index_error = 1'b1;
    if (n >= length_reg) return res;
    p1 = ({48'd0, n} << 32) / {48'd0, length_reg};
    p2 = {p1[30:0], 1'b0};
    acc = (longint'(a0_reg) <<< 30) - longint'(a1_reg) * cos_turn(p1[31:0])
          + longint'(a2_reg) * cos_turn(p2);
    value = (acc + (64'sd1 <<< 29)) >>> 30;
    if (value > 262143) value = 262143;
    if (value < -262144) value = -262144;
    res.window_value = value[csw_pkg::OUT_W-1:0];
    res.index_error = 1'b0;
    return res;
  endfunction

  // Input acceptance and prediction.
  always @(posedge clk) begin
    in_fire <= in_tvalid && in_tready;
    if (in_tvalid && in_tready) expected_samples.push_back(window_sample(in_tdata));
  end

  // Result checking.
  always @(posedge clk) begin
    window_result_t exp_r;
    if (out_tvalid && out_tready) begin
      if (expected_samples.size() == 0) begin
        $error("unexpected result: window_value %0d",
               $signed(out_tdata[csw_pkg::OUT_W-1:0]));
        error_count++;
      end else begin
        exp_r = expected_samples.pop_front();
        if (out_tdata[csw_pkg::OUT_W-1:0] !== exp_r.window_value) begin
          $error("window_value expected %0d actual %0d", $signed(exp_r.window_value),
                 $signed(out_tdata[csw_pkg::OUT_W-1:0]));
          error_count++;
        end
        if (out_tuser !== exp_r.index_error) begin
          $error("index_error expected %0b actual %0b", exp_r.index_error, out_tuser);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Request driver: bursts of random length separated by random gaps.
  always @(negedge clk) begin
    if (in_fire) void'(pending_index.pop_front());
    if (in_tvalid && !in_fire) begin
      in_tvalid <= 1'b1;
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      in_tvalid <= 1'b0;
    end else if (pending_index.size() > 0) begin
      in_tvalid <= 1'b1;
      in_tdata <= pending_index[0];
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 40);
        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // Result receiver: alternates between always ready and random stalls.
  always @(negedge clk) begin
    stall_cycle <= stall_cycle + 1;
    if ((stall_cycle / 300) % 3 == 0) out_tready <= 1'b1;
    else if ((stall_cycle / 300) % 3 == 1) out_tready <= ($urandom_range(0, 3) != 0);
    else out_tready <= ($urandom_range(0, 1) == 0);
  end

  task automatic write_reg(csw_pkg::csw_reg_t which, bit [16:0] value);
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b1;
    cfg_paddr = {which, 2'b00};
    cfg_pwdata = {15'd0, value};
    @(negedge clk);
    cfg_penable = 1'b1;
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    case (which)
      csw_pkg::REG_LENGTH: length_reg = value[15:0];
      csw_pkg::REG_COEF0:  a0_reg = value;
      csw_pkg::REG_COEF1:  a1_reg = value;
      csw_pkg::REG_COEF2:  a2_reg = value;
      default: ;
    endcase
  endtask

  task automatic set_window(bit [15:0] len, bit [16:0] c0, bit [16:0] c1, bit [16:0] c2);
    write_reg(csw_pkg::REG_LENGTH, {1'b0, len});
    write_reg(csw_pkg::REG_COEF0, c0);
    write_reg(csw_pkg::REG_COEF1, c1);
    write_reg(csw_pkg::REG_COEF2, c2);
  endtask

  task automatic drain;
    while (pending_index.size() > 0 || expected_samples.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic bit [16:0] random_coef();
    case ($urandom_range(0, 5))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'd131071;
      default: return 17'($urandom_range(0, 131071));
    endcase
  endfunction

  initial begin
    bit [15:0] len;
    int        k;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Hann at reset: ends, center, quarter points and out-of-range indexes.
    pending_index = '{16'd0, 16'd1, 16'd64, 16'd128, 16'd192, 16'd255, 16'd256,
                      16'd65535, 16'd200};
    drain();
    // Zero length flags every index; length one has a single sample.
    set_window(16'd0, 17'd27959, 17'd32768, 17'd5243);
    pending_index = '{16'd0, 16'd1, 16'd65535};
    drain();
    set_window(16'd1, 17'd35617, 17'd29919, 17'd0);
    pending_index = '{16'd0, 16'd1};
    drain();
    // Largest coefficients push the center above the output range.
    set_window(16'd65535, 17'd131071, 17'd131071, 17'd131071);
    pending_index = '{16'd0, 16'd32767, 16'd32768, 16'd16384, 16'd65534, 16'd65535};
    drain();
    set_window(16'd1000, 17'd0, 17'd131071, 17'd65536);
    pending_index = '{16'd0, 16'd250, 16'd500, 16'd999, 16'd1000};
    drain();

    for (int phase_idx = 0; phase_idx < 8; phase_idx++) begin
      case ($urandom_range(0, 4))
        0: len = 16'($urandom_range(1, 16));
        1: len = 16'd65535;
        2: len = (phase_idx == 3) ? 16'd0 : 16'($urandom_range(17, 4096));
        default: len = 16'($urandom);
      endcase
      set_window(len, random_coef(), random_coef(), random_coef());
      for (k = 0; k < 250; k++) begin
        if ($urandom_range(0, 9) < 8 && len > 0)
          pending_index.push_back(16'($urandom_range(0, len - 1)));
        else pending_index.push_back(16'($urandom));
      end
      drain();
    end

    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

>>> filelist.f
+incdir+rtl
rtl/csw_pkg.sv
rtl/csw_div.sv
rtl/csw_cos.sv
rtl/csw_mix.sv
rtl/cosine_sum_window_generator_top.sv
tb/cosine_sum_window_generator_top_tb.sv
